>>> hdl/csg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the midpoint circle span generator.
// Used by csg_walker, csg_span_emit and midpoint_circle_span_generator.
package csg_pkg;

	localparam int COORD_BITS = 12;
	localparam int SPAN_BITS  = 14;
	localparam int STEP_BITS  = COORD_BITS + 1;
	localparam int DEC_BITS   = 16;
	localparam int INDEX_BITS = 2;
	localparam int BEAT_BITS  = 3;

	localparam logic [BEAT_BITS-1:0] LAST_BEAT = 3'd7;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	localparam logic [INDEX_BITS-1:0] REG_CENTER_X     = 2'd0;
	localparam logic [INDEX_BITS-1:0] REG_CENTER_Y     = 2'd1;
	localparam logic [INDEX_BITS-1:0] REG_SCREEN_WIDTH = 2'd2;

	localparam logic [COORD_BITS-1:0] RST_CENTER_X     = COORD_BITS'(400);
	localparam logic [COORD_BITS-1:0] RST_CENTER_Y     = COORD_BITS'(225);
	localparam logic [COORD_BITS-1:0] RST_SCREEN_WIDTH = COORD_BITS'(800);

	typedef struct packed {
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [COORD_BITS-1:0] sw;
	} geom_t;

	// Everything the emitter needs to produce the eight spans of one step.
	typedef struct packed {
		logic signed [STEP_BITS-1:0] x;
		logic signed [STEP_BITS-1:0] y;
		geom_t                       geom;
		logic                        done;
	} span_set_t;

endpackage

>>> hdl/csg_walker.sv
`timescale 1ns / 1ps
// Octant walker: holds x, y and the decision term and advances them per step.
// Depends on csg_pkg.
module csg_walker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic                            req_type,
	input  logic [csg_pkg::COORD_BITS-1:0]  radius,
	input  csg_pkg::geom_t                  geom,
	output logic                            load,
	output csg_pkg::span_set_t              span_set
);

	logic signed [csg_pkg::STEP_BITS-1:0] step_x_q;
	logic signed [csg_pkg::STEP_BITS-1:0] step_y_q;
	logic signed [csg_pkg::DEC_BITS-1:0]  decision_q;
	logic                                 active_q;

	logic signed [csg_pkg::STEP_BITS-1:0] next_x;
	logic signed [csg_pkg::STEP_BITS-1:0] next_y;
	logic signed [csg_pkg::DEC_BITS-1:0]  next_dec;
	logic signed [csg_pkg::DEC_BITS-1:0]  x_ext;
	logic signed [csg_pkg::DEC_BITS-1:0]  y_ext;
	logic                                 dec_le0;
	logic                                 walk_done;

	assign x_ext   = csg_pkg::DEC_BITS'(step_x_q);
	assign y_ext   = csg_pkg::DEC_BITS'(step_y_q);
	assign dec_le0 = decision_q[csg_pkg::DEC_BITS-1] || (decision_q == '0);

	// Standard midpoint update on the old x and y.
	always_comb begin
		next_x = step_x_q + csg_pkg::STEP_BITS'(1);
		if (dec_le0) begin
			next_dec = decision_q + (x_ext <<< 1) + csg_pkg::DEC_BITS'(3);
			next_y   = step_y_q;
		end else begin
			next_dec = decision_q + ((x_ext - y_ext) <<< 1) + csg_pkg::DEC_BITS'(5);
			next_y   = step_y_q - csg_pkg::STEP_BITS'(1);
		end
	end

	assign walk_done = next_x > next_y;
	assign load = accept && (req_type == csg_pkg::REQ_STEP) && active_q
		&& !(step_x_q > step_y_q);

	assign span_set.x    = step_x_q;
	assign span_set.y    = step_y_q;
	assign span_set.geom = geom;
	assign span_set.done = walk_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q   <= '0;
			step_y_q   <= '0;
			decision_q <= '0;
			active_q   <= 1'b0;
		end else if (accept && (req_type == csg_pkg::REQ_START)) begin
			step_x_q   <= '0;
			step_y_q   <= csg_pkg::STEP_BITS'(radius);
			decision_q <= csg_pkg::DEC_BITS'(1) - csg_pkg::DEC_BITS'(radius);
			active_q   <= 1'b1;
		end else if (load) begin
			step_x_q   <= next_x;
			step_y_q   <= next_y;
			decision_q <= next_dec;
			if (walk_done) begin
				active_q <= 1'b0;
			end
		end
	end

	// A live walk never has x beyond y.
	a_active_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !(step_x_q > step_y_q))
		else $error("walker active with x greater than y");

	// A step that ends the walk leaves the walker inactive.
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load && walk_done) |=> !active_q)
		else $error("walker still active after final step");

	// A start always leaves the walk at x = 0 and active.
	a_start_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == csg_pkg::REQ_START)) |=> (active_q && (step_x_q == '0)))
		else $error("start did not reset the walk");

endmodule

>>> hdl/csg_span_emit.sv
`timescale 1ns / 1ps
// Span emitter: holds one step's values and sends its eight spans, one beat a cycle
// while out_ready is high. Depends on csg_pkg.
module csg_span_emit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  csg_pkg::span_set_t                    span_set,
	output logic                                  can_load,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [csg_pkg::SPAN_BITS-1:0]  row,
	output logic signed [csg_pkg::SPAN_BITS-1:0]  x_from,
	output logic signed [csg_pkg::SPAN_BITS-1:0]  x_to,
	output logic                                  last,
	output logic                                  circle_done
);

	csg_pkg::span_set_t             set_q;
	logic                           busy_q;
	logic [csg_pkg::BEAT_BITS-1:0]  beat_q;

	logic signed [csg_pkg::SPAN_BITS-1:0] x_s;
	logic signed [csg_pkg::SPAN_BITS-1:0] y_s;
	logic signed [csg_pkg::SPAN_BITS-1:0] row_term;
	logic signed [csg_pkg::SPAN_BITS-1:0] to_term;
	logic signed [csg_pkg::SPAN_BITS-1:0] cx_s;
	logic signed [csg_pkg::SPAN_BITS-1:0] cy_s;
	logic                                 row_neg;
	logic                                 to_neg;
	logic                                 from_right;
	logic                                 beat_done;

	assign beat_done = out_valid && out_ready;
	assign can_load  = !busy_q || ((beat_q == csg_pkg::LAST_BEAT) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			beat_q <= '0;
		end else if (beat_done) begin
			if (beat_q == csg_pkg::LAST_BEAT) begin
				busy_q <= 1'b0;
			end
			beat_q <= beat_q + csg_pkg::BEAT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			set_q <= span_set;
		end
	end

	assign x_s  = csg_pkg::SPAN_BITS'(set_q.x);
	assign y_s  = csg_pkg::SPAN_BITS'(set_q.y);
	assign cx_s = csg_pkg::SPAN_BITS'(set_q.geom.cx);
	assign cy_s = csg_pkg::SPAN_BITS'(set_q.geom.cy);

	// Beats 0-3 are the rows at cy+/-y, beats 4-7 the rows at cy-/+x.
	// Rows go below the centre on beats 2 to 5; the boundary column lies left
	// of centre on beats 1, 3, 4 and 6; the right edge is the start on 0, 2, 5, 7.
	assign row_neg    = beat_q[2] ^ beat_q[1];
	assign to_neg     = beat_q[2] ^ beat_q[0];
	assign from_right = beat_q[2] == beat_q[0];
	assign row_term   = beat_q[2] ? x_s : y_s;
	assign to_term    = beat_q[2] ? y_s : x_s;

	assign row    = row_neg ? (cy_s - row_term) : (cy_s + row_term);
	assign x_to   = to_neg ? (cx_s - to_term) : (cx_s + to_term);
	assign x_from = from_right ? csg_pkg::SPAN_BITS'(set_q.geom.sw) : '0;

	assign out_valid   = busy_q;
	assign last        = beat_q == csg_pkg::LAST_BEAT;
	assign circle_done = last && set_q.done;

	// Loading over a busy emitter is only allowed as its final beat leaves.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(load && busy_q) |-> (beat_done && last))
		else $error("span set loaded over unfinished step");

	// The final beat leaving without a new load frees the emitter.
	a_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_done && last && !load) |=> !busy_q)
		else $error("emitter still busy after eighth span");

	// A step always starts from its first span.
	a_first_beat: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (busy_q && (beat_q == '0)))
		else $error("step did not start at first span");

endmodule

>>> hdl/midpoint_circle_span_generator.sv
`timescale 1ns / 1ps
// Top level of the midpoint circle span generator: configuration registers,
// walker and span emitter. Depends on csg_pkg, csg_walker and csg_span_emit.
//
//   channel  direction  handshake               payload
//   in       to block   in_valid / in_ready     req_type, radius
//   out      from block out_valid / out_ready   row, x_from, x_to, last, circle_done
//   cfg      to block   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A step request yields eight span beats, one per cycle while out_ready is high;
// the single output channel sets the step rate, and the next step is taken in the
// cycle its predecessor's eighth beat leaves. Start requests are taken every cycle.
// Reset clears the walk (no circle active) and loads the default geometry.
// A stall on out holds the current span and blocks further steps only.
module midpoint_circle_span_generator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  req_type,
	input  logic [csg_pkg::COORD_BITS-1:0]        radius,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [csg_pkg::SPAN_BITS-1:0]  row,
	output logic signed [csg_pkg::SPAN_BITS-1:0]  x_from,
	output logic signed [csg_pkg::SPAN_BITS-1:0]  x_to,
	output logic                                  last,
	output logic                                  circle_done,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [csg_pkg::INDEX_BITS-1:0]        cfg_index,
	input  logic [csg_pkg::COORD_BITS-1:0]        cfg_data
);

	csg_pkg::geom_t     geom_q;
	csg_pkg::span_set_t span_set;
	logic               accept;
	logic               load;
	logic               can_load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.cx <= csg_pkg::RST_CENTER_X;
			geom_q.cy <= csg_pkg::RST_CENTER_Y;
			geom_q.sw <= csg_pkg::RST_SCREEN_WIDTH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				csg_pkg::REG_CENTER_X:     geom_q.cx <= cfg_data;
				csg_pkg::REG_CENTER_Y:     geom_q.cy <= cfg_data;
				csg_pkg::REG_SCREEN_WIDTH: geom_q.sw <= cfg_data;
				default: ;
			endcase
		end
	end

	// Starts only touch the walker, so they never wait for the emitter.
	assign in_ready = can_load || (req_type == csg_pkg::REQ_START);
	assign accept   = in_valid && in_ready;

	csg_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (req_type),
		.radius   (radius),
		.geom     (geom_q),
		.load     (load),
		.span_set (span_set)
	);

	csg_span_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.span_set    (span_set),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.row         (row),
		.x_from      (x_from),
		.x_to        (x_to),
		.last        (last),
		.circle_done (circle_done)
	);

endmodule
